// ----- rtl/bisw_pkg.sv -----
// Shared event codes, cause codes and word types of the bus idle sleep/wake manager.
package bisw_pkg;

   localparam logic [3:0] EV_ACTIVITY  = 4'd0;
   localparam logic [3:0] EV_LOCK      = 4'd1;
   localparam logic [3:0] EV_AWAKE     = 4'd2;
   localparam logic [3:0] EV_CHECK     = 4'd3;
   localparam logic [3:0] EV_ENTER     = 4'd4;
   localparam logic [3:0] EV_EXIT      = 4'd5;
   localparam logic [3:0] EV_STOPWAKE  = 4'd6;
   localparam logic [3:0] EV_CLEAR     = 4'd7;
   localparam logic [3:0] EV_RESETDIAG = 4'd8;
   localparam logic [3:0] EV_INIT      = 4'd9;

   localparam logic [1:0] SLEEP_NONE    = 2'd0;
   localparam logic [1:0] SLEEP_TIMEOUT = 2'd1;
   localparam logic [1:0] SLEEP_LOCK    = 2'd2;
   localparam logic [1:0] SLEEP_DIRECT  = 2'd3;

   localparam logic [2:0] WAKE_NONE      = 3'd0;
   localparam logic [2:0] WAKE_BUS_RX    = 3'd1;
   localparam logic [2:0] WAKE_MANUAL    = 3'd2;
   localparam logic [2:0] WAKE_EXIT      = 3'd3;
   localparam logic [2:0] WAKE_STOP_RX   = 3'd4;
   localparam logic [2:0] WAKE_STOP_XCVR = 3'd5;

   localparam logic [1:0] SRC_BUS_RX = 2'd1;
   localparam logic [1:0] SRC_XCVR   = 2'd2;

   localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd60000;

   localparam logic CSR_IDX_IDLE_TIMEOUT = 1'b0;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [31:0] now_ms;
      logic [1:0]  wake_source;
   } event_type;

   typedef struct packed {
      logic        is_sleeping;
      logic        sleep_pending;
      logic [31:0] idle_time_ms;
      logic [1:0]  sleep_cause;
      logic [2:0]  wake_cause;
      logic [31:0] request_total;
      logic [31:0] enter_total;
      logic [31:0] wake_total;
      logic [31:0] request_stamp_ms;
      logic [31:0] enter_stamp_ms;
      logic [31:0] wake_stamp_ms;
      logic [31:0] idle_at_request_ms;
   } result_type;

endpackage

// ----- rtl/bisw_core.sv -----
// Sleep policy state, its per-event update and the registered result word.
module bisw_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bisw_pkg::event_type   ev,
   input  logic [31:0]           idle_timeout_ms,
   output bisw_pkg::result_type  result
);

   typedef struct packed {
      logic [31:0] activity;
      logic        sleeping;
      logic        pending;
      logic [1:0]  sleep_cause;
      logic [2:0]  wake_cause;
      logic [31:0] request_cnt;
      logic [31:0] enter_cnt;
      logic [31:0] wake_cnt;
      logic [31:0] request_stamp;
      logic [31:0] enter_stamp;
      logic [31:0] wake_stamp;
      logic [31:0] idle_at_request;
   } state_type;

   state_type            st_ff, st_in;
   bisw_pkg::result_type result_ff, result_in;
   logic [31:0]          idle_now;

   assign idle_now = ev.now_ms - st_ff.activity;

   always_comb begin
      st_in = st_ff;
      unique case (ev.req_type)
         bisw_pkg::EV_ACTIVITY: begin
            st_in.activity = ev.now_ms;
            if (st_ff.pending && st_ff.sleep_cause == bisw_pkg::SLEEP_TIMEOUT) begin
               st_in.pending = 1'b0;
            end
            if (st_ff.sleeping) begin
               st_in.wake_cause = bisw_pkg::WAKE_BUS_RX;
               st_in.wake_stamp = ev.now_ms;
               st_in.wake_cnt   = st_ff.wake_cnt + 32'd1;
            end
            st_in.sleeping = 1'b0;
         end
         bisw_pkg::EV_LOCK: begin
            if (!st_ff.sleeping && !st_ff.pending) begin
               st_in.pending         = 1'b1;
               st_in.request_cnt     = st_ff.request_cnt + 32'd1;
               st_in.sleep_cause     = bisw_pkg::SLEEP_LOCK;
               st_in.request_stamp   = ev.now_ms;
               st_in.idle_at_request = idle_now;
            end
         end
         bisw_pkg::EV_AWAKE: begin
            st_in.sleeping   = 1'b0;
            st_in.pending    = 1'b0;
            st_in.activity   = ev.now_ms;
            st_in.wake_cause = bisw_pkg::WAKE_MANUAL;
            st_in.wake_stamp = ev.now_ms;
            st_in.wake_cnt   = st_ff.wake_cnt + 32'd1;
         end
         bisw_pkg::EV_CHECK: begin
            if (!st_ff.sleeping && !st_ff.pending && idle_now >= idle_timeout_ms) begin
               st_in.pending         = 1'b1;
               st_in.request_cnt     = st_ff.request_cnt + 32'd1;
               st_in.sleep_cause     = bisw_pkg::SLEEP_TIMEOUT;
               st_in.request_stamp   = ev.now_ms;
               st_in.idle_at_request = idle_now;
            end
         end
         bisw_pkg::EV_ENTER: begin
            if (!st_ff.sleeping) begin
               st_in.sleeping    = 1'b1;
               st_in.enter_cnt   = st_ff.enter_cnt + 32'd1;
               st_in.enter_stamp = ev.now_ms;
               if (st_ff.sleep_cause == bisw_pkg::SLEEP_NONE) begin
                  st_in.sleep_cause = bisw_pkg::SLEEP_DIRECT;
               end
            end
         end
         bisw_pkg::EV_EXIT: begin
            if (st_ff.sleeping) begin
               st_in.sleeping = 1'b0;
               st_in.pending  = 1'b0;
               st_in.activity = ev.now_ms;
               // plain unsigned compare of the stamps, no wrap handling
               if (st_ff.wake_cause == bisw_pkg::WAKE_NONE ||
                   st_ff.wake_stamp < st_ff.enter_stamp) begin
                  st_in.wake_cause = bisw_pkg::WAKE_EXIT;
                  st_in.wake_stamp = ev.now_ms;
                  st_in.wake_cnt   = st_ff.wake_cnt + 32'd1;
               end
            end
         end
         bisw_pkg::EV_STOPWAKE: begin
            if (ev.wake_source == bisw_pkg::SRC_BUS_RX ||
                ev.wake_source == bisw_pkg::SRC_XCVR) begin
               st_in.wake_cause = (ev.wake_source == bisw_pkg::SRC_BUS_RX) ?
                                  bisw_pkg::WAKE_STOP_RX : bisw_pkg::WAKE_STOP_XCVR;
               st_in.wake_stamp = ev.now_ms;
               st_in.wake_cnt   = st_ff.wake_cnt + 32'd1;
            end
         end
         bisw_pkg::EV_CLEAR: begin
            st_in.pending = 1'b0;
         end
         bisw_pkg::EV_RESETDIAG, bisw_pkg::EV_INIT: begin
            st_in.sleep_cause     = bisw_pkg::SLEEP_NONE;
            st_in.wake_cause      = bisw_pkg::WAKE_NONE;
            st_in.request_cnt     = '0;
            st_in.enter_cnt       = '0;
            st_in.wake_cnt        = '0;
            st_in.request_stamp   = '0;
            st_in.enter_stamp     = '0;
            st_in.wake_stamp      = '0;
            st_in.idle_at_request = '0;
            if (ev.req_type == bisw_pkg::EV_INIT) begin
               st_in.activity = ev.now_ms;
               st_in.sleeping = 1'b0;
               st_in.pending  = 1'b0;
            end
         end
         default: begin
            st_in = st_ff;
         end
      endcase
   end

   always_comb begin
      result_in.is_sleeping        = st_in.sleeping;
      result_in.sleep_pending      = st_in.pending;
      result_in.idle_time_ms       = ev.now_ms - st_in.activity;
      result_in.sleep_cause        = st_in.sleep_cause;
      result_in.wake_cause         = st_in.wake_cause;
      result_in.request_total      = st_in.request_cnt;
      result_in.enter_total        = st_in.enter_cnt;
      result_in.wake_total         = st_in.wake_cnt;
      result_in.request_stamp_ms   = st_in.request_stamp;
      result_in.enter_stamp_ms     = st_in.enter_stamp;
      result_in.wake_stamp_ms      = st_in.wake_stamp;
      result_in.idle_at_request_ms = st_in.idle_at_request;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (load) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/bus_idle_sleep_wake_manager.sv -----
// Top level of the bus idle sleep/wake manager: handshake, input stage and CSR port.
//
// Each request word is one timestamped bus event (activity, lock, awake, timeout
// check, enter, exit, stop-mode wakeup, clear, diagnostics reset, init). The block
// updates its sleep and pending flags, the last-activity stamp and its diagnostic
// counters and stamps, and returns exactly one response word per event with the
// flags, the current idle time and all diagnostics. One event is taken every cycle
// while the response side keeps up. A request word lands in the input register at
// the edge that takes it; the state update and the response register load from it
// once the response register is empty or being drained, and its response word is then offered.
// While the response side stalls the block holds two words, one in each register,
// and then drops req_ready until a response word leaves. The idle timeout lives in
// the CSR at byte address 0 (reset 60000 ms) and should only be written while no
// event is in flight. All times are 32-bit millisecond ticks that wrap modulo 2^32.
module bus_idle_sleep_wake_manager (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_type,
   input  logic [31:0] req_now_ms,
   input  logic [1:0]  req_wake_source,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_sleeping,
   output logic        rsp_sleep_pending,
   output logic [31:0] rsp_idle_time_ms,
   output logic [1:0]  rsp_sleep_cause,
   output logic [2:0]  rsp_wake_cause,
   output logic [31:0] rsp_request_total,
   output logic [31:0] rsp_enter_total,
   output logic [31:0] rsp_wake_total,
   output logic [31:0] rsp_request_stamp_ms,
   output logic [31:0] rsp_enter_stamp_ms,
   output logic [31:0] rsp_wake_stamp_ms,
   output logic [31:0] rsp_idle_at_request_ms,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                 in_valid_ff, in_valid_in;
   bisw_pkg::event_type  in_word_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   logic [31:0]          timeout_ff;
   logic                 csr_write;
   bisw_pkg::result_type result;

   // response register can take a word when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // move the held input word into the state update and response register
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the request word; hold it while the response side stalls
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.req_type    <= req_type;
         in_word_ff.now_ms      <= req_now_ms;
         in_word_ff.wake_source <= req_wake_source;
      end
   end

   // CSR: single idle timeout register, write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= bisw_pkg::IDLE_TIMEOUT_RESET;
      end else if (csr_write && paddr[2] == bisw_pkg::CSR_IDX_IDLE_TIMEOUT) begin
         timeout_ff <= pwdata;
      end
   end

   // paddr[1:0] is the byte lane within the word and does not select a register; a read returns zero unless it is 0
   assign prdata = (paddr[2] == bisw_pkg::CSR_IDX_IDLE_TIMEOUT && paddr[1:0] == 2'b00) ?
                   timeout_ff : '0;

   bisw_core u_core (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .ev              (in_word_ff),
      .idle_timeout_ms (timeout_ff),
      .result          (result)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_is_sleeping        = result.is_sleeping;
   assign rsp_sleep_pending      = result.sleep_pending;
   assign rsp_idle_time_ms       = result.idle_time_ms;
   assign rsp_sleep_cause        = result.sleep_cause;
   assign rsp_wake_cause         = result.wake_cause;
   assign rsp_request_total      = result.request_total;
   assign rsp_enter_total        = result.enter_total;
   assign rsp_wake_total         = result.wake_total;
   assign rsp_request_stamp_ms   = result.request_stamp_ms;
   assign rsp_enter_stamp_ms     = result.enter_stamp_ms;
   assign rsp_wake_stamp_ms      = result.wake_stamp_ms;
   assign rsp_idle_at_request_ms = result.idle_at_request_ms;

endmodule
